// File: hw/rtl/tem_pkg.sv
package tem_pkg;

    localparam int MAX_PHASES   = 3;
    localparam int INPUT_PHASES = 3;
    localparam int SAMPLE_BITS  = 16;
    localparam int TIME_BITS    = 48;
    localparam int DT_BITS      = 32;
    localparam int ENERGY_BITS  = 64;
    localparam int PC_BITS      = 2;
    localparam int PC_RESET     = 3;

    // phases that are actually carried by an item
    localparam int PHASES    = (MAX_PHASES < INPUT_PHASES) ? MAX_PHASES : INPUT_PHASES;
    localparam int CNT_BITS  = $clog2(PHASES + 1);
    localparam int IDX_BITS  = (PHASES > 1) ? $clog2(PHASES) : 1;

    localparam int PROD_BITS = 2 * SAMPLE_BITS;
    localparam int PAIR_BITS = PROD_BITS + 1;
    localparam int TERM_BITS = PAIR_BITS + DT_BITS + 1;
    localparam int SUM_BITS  = TERM_BITS + $clog2(PHASES);
    localparam int TOT_BITS  = (SUM_BITS > ENERGY_BITS) ? SUM_BITS + 1 : ENERGY_BITS + 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [PROD_BITS-1:0]   power_t;
    typedef logic [TIME_BITS-1:0]          time_t;
    typedef logic [DT_BITS-1:0]            dt_t;
    typedef logic signed [ENERGY_BITS-1:0] energy_t;
    typedef logic [PC_BITS-1:0]            phase_count_t;
    typedef logic [CNT_BITS-1:0]           phase_cnt_t;

    typedef struct packed {
        dt_t                                dt;
        logic                               first;
        phase_cnt_t                         enabled;
        logic [PHASES-1:0][SAMPLE_BITS-1:0] voltage;
        logic [PHASES-1:0][SAMPLE_BITS-1:0] current;
    } tem_job_t;

endpackage

// File: hw/rtl/tem_sample_if.sv
interface tem_sample_if
    import tem_pkg::*;
();
    logic    valid;
    logic    ready;
    time_t   timestamp_us;
    sample_t voltage_a;
    sample_t current_a;
    sample_t voltage_b;
    sample_t current_b;
    sample_t voltage_c;
    sample_t current_c;

    modport source (
        output valid, timestamp_us, voltage_a, current_a, voltage_b, current_b,
               voltage_c, current_c,
        input  ready
    );
    modport sink (
        input  valid, timestamp_us, voltage_a, current_a, voltage_b, current_b,
               voltage_c, current_c,
        output ready
    );
endinterface

// File: hw/rtl/tem_energy_if.sv
interface tem_energy_if
    import tem_pkg::*;
();
    logic    valid;
    logic    ready;
    energy_t energy_total;
    logic    saturated;

    modport source (
        output valid, energy_total, saturated,
        input  ready
    );
    modport sink (
        input  valid, energy_total, saturated,
        output ready
    );
endinterface

// File: hw/rtl/tem_front.sv
module tem_front
    import tem_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  phase_count_t cfg_wr_data,
    tem_sample_if.sink   samples,
    output logic         push_valid,
    input  logic         push_ready,
    output tem_job_t     push_job
);

    localparam int EN_BITS = (CNT_BITS > PC_BITS) ? CNT_BITS : PC_BITS;

    phase_count_t phase_count_reg;
    time_t        prev_time_reg;
    logic         have_prev_reg;

    logic                                     accept;
    time_t                                    diff;
    logic [INPUT_PHASES-1:0][SAMPLE_BITS-1:0] v_all;
    logic [INPUT_PHASES-1:0][SAMPLE_BITS-1:0] i_all;

    assign samples.ready = push_ready;
    assign push_valid    = samples.valid;
    assign accept        = samples.valid && push_ready;

    // elapsed time wraps with the timestamp, then clamps to the dt range
    assign diff = samples.timestamp_us - prev_time_reg;

    assign v_all = {samples.voltage_c, samples.voltage_b, samples.voltage_a};
    assign i_all = {samples.current_c, samples.current_b, samples.current_a};

    always_comb
    begin
        push_job.dt      = (|diff[TIME_BITS-1:DT_BITS]) ? '1 : diff[DT_BITS-1:0];
        push_job.first   = !have_prev_reg;
        push_job.voltage = v_all[PHASES-1:0];
        push_job.current = i_all[PHASES-1:0];
        if (EN_BITS'(phase_count_reg) > EN_BITS'(PHASES))
        begin
            push_job.enabled = CNT_BITS'(PHASES);
        end
        else
        begin
            push_job.enabled = CNT_BITS'(phase_count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_count_reg <= PC_BITS'(PC_RESET);
            prev_time_reg   <= '0;
            have_prev_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                phase_count_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                prev_time_reg <= samples.timestamp_us;
                have_prev_reg <= 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/tem_queue.sv
module tem_queue
    import tem_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  tem_job_t push_job,
    output logic     pop_valid,
    input  logic     pop_ready,
    output tem_job_t pop_job
);

    tem_job_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg;
    logic [QPTR_BITS-1:0]   rd_ptr_reg;
    logic [QCNT_BITS-1:0]   count_reg;

    logic [QPTR_BITS-1:0]   wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_next;
    logic [QCNT_BITS-1:0]   count_next;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + QCNT_BITS'(do_push) - QCNT_BITS'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: hw/rtl/tem_back.sv
module tem_back
    import tem_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         pop_valid,
    output logic         pop_ready,
    input  tem_job_t     pop_job,
    tem_energy_if.source energy
);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

    state_t                      state_reg,      state_next;
    tem_job_t                    job_reg,        job_next;
    phase_cnt_t                  iss_reg,        iss_next;
    power_t                      power_reg,      power_next;
    logic                        p_vld_reg,      p_vld_next;
    logic [IDX_BITS-1:0]         p_idx_reg,      p_idx_next;
    logic signed [TERM_BITS-1:0] term_reg,       term_next;
    logic                        t_vld_reg,      t_vld_next;
    logic signed [SUM_BITS-1:0]  sum_reg,        sum_next;
    power_t                      prev_reg [PHASES];
    power_t                      prev_next [PHASES];
    energy_t                     acc_reg,        acc_next;
    logic                        sat_reg,        sat_next;
    logic                        out_valid_reg,  out_valid_next;
    energy_t                     out_energy_reg, out_energy_next;
    logic                        out_sat_reg,    out_sat_next;

    logic [IDX_BITS-1:0]         iss_idx;
    logic                        issue;
    logic                        drained;
    power_t                      power_calc;
    logic signed [PAIR_BITS-1:0] pair;
    logic signed [DT_BITS:0]     dtx;
    logic signed [TERM_BITS-1:0] term_calc;
    logic signed [TOT_BITS-1:0]  total;
    logic                        fits;
    energy_t                     clamped;

    assign pop_ready           = (state_reg == ST_IDLE);
    assign energy.valid        = out_valid_reg;
    assign energy.energy_total = out_energy_reg;
    assign energy.saturated    = out_sat_reg;

    // power, trapezoid term and running sum form a three-stage pipe over the phases
    assign iss_idx    = iss_reg[IDX_BITS-1:0];
    assign issue      = (state_reg == ST_RUN) && (iss_reg < CNT_BITS'(PHASES));
    assign drained    = (iss_reg == CNT_BITS'(PHASES)) && !p_vld_reg && !t_vld_reg;
    assign power_calc = $signed(job_reg.voltage[iss_idx]) * $signed(job_reg.current[iss_idx]);
    assign pair       = PAIR_BITS'(prev_reg[p_idx_reg]) + PAIR_BITS'(power_reg);
    assign dtx        = $signed({1'b0, job_reg.dt});
    assign term_calc  = pair * dtx;

    // halve rounding down, add, then clamp to the signed energy range
    assign total   = TOT_BITS'(acc_reg) + TOT_BITS'(sum_reg >>> 1);
    assign fits    = (&total[TOT_BITS-1:ENERGY_BITS-1]) || !(|total[TOT_BITS-1:ENERGY_BITS-1]);
    assign clamped = fits ? total[ENERGY_BITS-1:0]
                   : (total[TOT_BITS-1] ? {1'b1, {(ENERGY_BITS-1){1'b0}}}
                                        : {1'b0, {(ENERGY_BITS-1){1'b1}}});

    always_comb
    begin
        state_next      = state_reg;
        job_next        = job_reg;
        iss_next        = iss_reg;
        power_next      = power_reg;
        p_vld_next      = issue;
        p_idx_next      = p_idx_reg;
        term_next       = term_reg;
        t_vld_next      = p_vld_reg;
        sum_next        = sum_reg;
        prev_next       = prev_reg;
        acc_next        = acc_reg;
        sat_next        = sat_reg;
        out_valid_next  = out_valid_reg && !energy.ready;
        out_energy_next = out_energy_reg;
        out_sat_next    = out_sat_reg;

        if (issue)
        begin
            power_next = power_calc;
            p_idx_next = iss_idx;
            iss_next   = iss_reg + 1'b1;
        end
        if (p_vld_reg)
        begin
            prev_next[p_idx_reg] = power_reg;
            if (!job_reg.first && (CNT_BITS'(p_idx_reg) < job_reg.enabled))
            begin
                term_next = term_calc;
            end
            else
            begin
                term_next = '0;
            end
        end
        if (t_vld_reg)
        begin
            sum_next = sum_reg + SUM_BITS'(term_reg);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    job_next   = pop_job;
                    iss_next   = '0;
                    sum_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (drained)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || energy.ready)
                begin
                    acc_next        = clamped;
                    sat_next        = sat_reg || !fits;
                    out_valid_next  = 1'b1;
                    out_energy_next = clamped;
                    out_sat_next    = sat_reg || !fits;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            job_reg        <= '0;
            iss_reg        <= '0;
            power_reg      <= '0;
            p_vld_reg      <= 1'b0;
            p_idx_reg      <= '0;
            term_reg       <= '0;
            t_vld_reg      <= 1'b0;
            sum_reg        <= '0;
            for (int k = 0; k < PHASES; k++)
            begin
                prev_reg[k] <= '0;
            end
            acc_reg        <= '0;
            sat_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_energy_reg <= '0;
            out_sat_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            job_reg        <= job_next;
            iss_reg        <= iss_next;
            power_reg      <= power_next;
            p_vld_reg      <= p_vld_next;
            p_idx_reg      <= p_idx_next;
            term_reg       <= term_next;
            t_vld_reg      <= t_vld_next;
            sum_reg        <= sum_next;
            prev_reg       <= prev_next;
            acc_reg        <= acc_next;
            sat_reg        <= sat_next;
            out_valid_reg  <= out_valid_next;
            out_energy_reg <= out_energy_next;
            out_sat_reg    <= out_sat_next;
        end
    end

endmodule

// File: hw/rtl/trapezoidal_energy_meter_unit.sv
// The back end finishes one item before it takes the next, walking the
// phases through one power multiplier and one dt multiplier.
// A two-entry queue lets the front take items while the back end is busy.
// Reset (rst_n low, asynchronous): energy total, saturation flag, previous
// powers and time cleared, phase count set to 3; first item adds nothing.
module trapezoidal_energy_meter_unit
    import tem_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  phase_count_t cfg_wr_data,
    tem_sample_if.sink   samples,
    tem_energy_if.source energy
);

    logic     push_valid;
    logic     push_ready;
    tem_job_t push_job;
    logic     pop_valid;
    logic     pop_ready;
    tem_job_t pop_job;

    tem_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .samples     (samples),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_job    (push_job)
    );

    tem_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    tem_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .energy    (energy)
    );

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tem_pkg::*;

    localparam int     DRAIN_CYCLES = 20;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     BLOCK_ITEMS  = 200;
    localparam int     BLOCKS       = 8;
    localparam int     REPORT_LIMIT = 10;
    localparam longint RUN_LIMIT_NS = 5_000_000;

    localparam time_t TIME_TOP = '1;
    localparam logic signed [127:0] ENERGY_HI = 128'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [127:0] ENERGY_LO = -ENERGY_HI - 1;

    typedef struct packed {
        time_t                              stamp;
        logic [PHASES-1:0][SAMPLE_BITS-1:0] volt;
        logic [PHASES-1:0][SAMPLE_BITS-1:0] amp;
    } sample_item_t;

    typedef struct packed {
        energy_t total;
        logic    sat;
    } energy_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b1;
    logic         cfg_wr_en;
    phase_count_t cfg_wr_data;

    tem_sample_if sample_ch ();
    tem_energy_if energy_ch ();

    trapezoidal_energy_meter_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .samples     (sample_ch),
        .energy      (energy_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // meter state as the block should hold it
    phase_count_t phase_count_now;
    power_t       last_power [PHASES];
    time_t        last_stamp;
    logic         have_last;
    energy_t      energy_sum;
    logic         clamp_seen;

    sample_item_t   pending_samples [$];
    energy_result_t expected_energy [$];
    sample_item_t   offered_sample;
    energy_result_t oldest_expected;
    time_t          gen_stamp;

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    bit sink_hold = 1'b0;

    int samples_accepted = 0;
    int results_checked = 0;
    int flagged_results = 0;
    int mismatches = 0;

    function automatic void accumulate_energy(input sample_item_t smp);
        power_t              now_power [PHASES];
        time_t               span;
        dt_t                 dt;
        logic signed [127:0] pair;
        logic signed [127:0] term_sum;
        logic signed [127:0] total;
        int                  active;
        energy_result_t      res;

        active = (int'(phase_count_now) > PHASES) ? PHASES : int'(phase_count_now);
        for (int k = 0; k < PHASES; k++)
            now_power[k] = $signed(smp.volt[k]) * $signed(smp.amp[k]);

        if (have_last)
        begin
            span = smp.stamp - last_stamp;
            dt = (span[TIME_BITS-1:DT_BITS] != 0) ? '1 : span[DT_BITS-1:0];
            term_sum = '0;
            for (int k = 0; k < active; k++)
            begin
                pair = last_power[k];
                pair = pair + now_power[k];
                term_sum = term_sum + pair * $signed({1'b0, dt});
            end
            total = energy_sum;
            // halving floors towards minus infinity
            total = total + (term_sum >>> 1);
            if (total > ENERGY_HI)
            begin
                energy_sum = ENERGY_HI[ENERGY_BITS-1:0];
                clamp_seen = 1'b1;
            end
            else if (total < ENERGY_LO)
            begin
                energy_sum = ENERGY_LO[ENERGY_BITS-1:0];
                clamp_seen = 1'b1;
            end
            else
                energy_sum = total[ENERGY_BITS-1:0];
        end

        // disabled phases still keep their power for later
        for (int k = 0; k < PHASES; k++)
            last_power[k] = now_power[k];
        last_stamp = smp.stamp;
        have_last = 1'b1;

        res.total = energy_sum;
        res.sat = clamp_seen;
        expected_energy.push_back(res);
    endfunction

    task automatic note_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("@%0t energy item %0d: %s expected %h got %h",
                     $time, results_checked, field, want, got);
    endtask

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_ch.valid        <= 1'b0;
            sample_ch.timestamp_us <= '0;
            sample_ch.voltage_a    <= '0;
            sample_ch.current_a    <= '0;
            sample_ch.voltage_b    <= '0;
            sample_ch.current_b    <= '0;
            sample_ch.voltage_c    <= '0;
            sample_ch.current_c    <= '0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                accumulate_energy(offered_sample);
                samples_accepted++;
            end
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    offered_sample = pending_samples.pop_front();
                    sample_ch.valid        <= 1'b1;
                    sample_ch.timestamp_us <= offered_sample.stamp;
                    sample_ch.voltage_a    <= offered_sample.volt[0];
                    sample_ch.current_a    <= offered_sample.amp[0];
                    sample_ch.voltage_b    <= offered_sample.volt[1];
                    sample_ch.current_b    <= offered_sample.amp[1];
                    sample_ch.voltage_c    <= offered_sample.volt[2];
                    sample_ch.current_c    <= offered_sample.amp[2];
                end
                else
                    sample_ch.valid <= 1'b0;
            end
        end
    end

    // energy monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            energy_ch.ready <= 1'b0;
        else
        begin
            if (energy_ch.valid && energy_ch.ready)
            begin
                results_checked++;
                if (expected_energy.size() == 0)
                    note_mismatch("item with nothing pending", '0, energy_ch.energy_total);
                else
                begin
                    oldest_expected = expected_energy.pop_front();
                    if (energy_ch.energy_total !== oldest_expected.total)
                        note_mismatch("energy_total", oldest_expected.total,
                                      energy_ch.energy_total);
                    if (energy_ch.saturated !== oldest_expected.sat)
                        note_mismatch("saturated", 64'(oldest_expected.sat),
                                      64'(energy_ch.saturated));
                end
                if (energy_ch.saturated === 1'b1)
                    flagged_results++;
            end
            energy_ch.ready <= !sink_hold && ($urandom_range(99) >= snk_stall_pct);
        end
    end

    task automatic wait_drained();
        while (pending_samples.size() != 0 || sample_ch.valid || expected_energy.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_phase_count(input phase_count_t pc);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= pc;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        phase_count_now = pc;
        @(negedge clk);
    endtask

    task automatic push_sample(input time_t stamp, input int va, input int ia,
                               input int vb, input int ib, input int vc, input int ic);
        sample_item_t smp;
        smp.stamp = stamp;
        smp.volt[0] = sample_t'(va);
        smp.amp[0]  = sample_t'(ia);
        smp.volt[1] = sample_t'(vb);
        smp.amp[1]  = sample_t'(ib);
        smp.volt[2] = sample_t'(vc);
        smp.amp[2]  = sample_t'(ic);
        gen_stamp = stamp;
        pending_samples.push_back(smp);
    endtask

    function automatic sample_t pick_sample();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return sample_t'(16'h8000);
        if (sel == 1)
            return sample_t'(16'h7FFF);
        if (sel == 2)
            return sample_t'(int'($urandom_range(8)) - 4);
        return sample_t'($urandom_range(16'hFFFF));
    endfunction

    task automatic push_random_sample();
        logic [63:0]  wide;
        int           sel;
        sample_item_t smp;
        wide = {$urandom(), $urandom()};
        sel = $urandom_range(99);
        // mostly steady sample spacing; some repeats, long gaps, wraps and jumps
        if (sel < 10)
            gen_stamp = gen_stamp;
        else if (sel < 70)
            gen_stamp = gen_stamp + time_t'($urandom_range(2000, 1));
        else if (sel < 80)
            gen_stamp = gen_stamp + time_t'(wide[31:0]);
        else if (sel < 88)
            gen_stamp = gen_stamp + wide[TIME_BITS-1:0];
        else if (sel < 95)
            gen_stamp = TIME_TOP - time_t'($urandom_range(3000));
        else
            gen_stamp = wide[TIME_BITS-1:0];
        smp.stamp = gen_stamp;
        for (int k = 0; k < PHASES; k++)
        begin
            smp.volt[k] = pick_sample();
            smp.amp[k]  = pick_sample();
        end
        pending_samples.push_back(smp);
    endtask

    initial
    begin
        phase_count_t block_pc [BLOCKS];
        int           src_pct [4];
        int           snk_pct [4];

        block_pc = '{2'd3, 2'd2, 2'd1, 2'd3, 2'd0, 2'd3, 2'd2, 2'd3};
        src_pct  = '{0, 71, 0, 29};
        snk_pct  = '{0, 0, 71, 29};

        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= phase_count_t'(PC_RESET);
        rst_n       <= 1'b0;

        phase_count_now = phase_count_t'(PC_RESET);
        for (int k = 0; k < PHASES; k++)
            last_power[k] = '0;
        last_stamp = '0;
        have_last  = 1'b0;
        energy_sum = '0;
        clamp_seen = 1'b0;
        gen_stamp  = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // first item only records; then zero dt, floor of odd negative sum
        push_sample(48'd1000, -32768, -32768, -32768, -32768, -32768, -32768);
        push_sample(48'd1000, 32767, 32767, 32767, -32768, 0, 0);
        push_sample(48'd1001, 1, -1, 0, 0, 0, 0);
        push_sample(48'd1002, 0, 0, 0, 0, 0, 0);
        push_sample(48'd1003, 2, 1, -1, -1, 0, 0);
        // long gap clamps dt, then wrap of the timestamp, then going backwards
        push_sample(TIME_TOP - 2, 100, -200, 300, 50, -7, 9);
        push_sample(48'd5, -1, 32767, 4, -4, 32767, 32767);
        push_sample(48'd2, 3, 3, -3, 3, 0, -1);
        // dt exactly at the 32-bit limit, then one above it
        push_sample(48'd2 + 48'hFFFF_FFFF, 1, 1, 1, 1, 1, 1);
        push_sample(gen_stamp + 48'h1_0000_0000, 1, 2, 3, 4, 5, 6);
        wait_drained();

        // no phase integrated, powers still tracked
        write_phase_count(2'd0);
        push_sample(gen_stamp + 48'd7, 500, 500, -500, 500, 9, 9);
        push_sample(gen_stamp + 48'd7, 600, 600, -600, 600, 8, 8);
        wait_drained();
        write_phase_count(2'd1);
        push_sample(gen_stamp + 48'd3, -700, 11, 700, 700, 12, -12);
        push_sample(gen_stamp + 48'd9, 701, 13, -701, 701, 14, 14);
        wait_drained();
        write_phase_count(2'd2);
        push_sample(gen_stamp + 48'd4, 5, 5, 6, -6, 7000, 7000);
        push_sample(gen_stamp + 48'd4, 5, 5, 6, -6, -7000, 7000);
        wait_drained();

        // phase C picks up from the power stored while it was off; then both clamps
        write_phase_count(2'd3);
        push_sample(gen_stamp + 48'd1, -32768, -32768, -32768, -32768, -32768, -32768);
        push_sample(gen_stamp + 48'h100_0000_0000,
                    -32768, -32768, -32768, -32768, -32768, -32768);
        push_sample(gen_stamp + 48'h100_0000_0000, 32767, -32768, 32767, -32768, 32767, -32768);
        push_sample(gen_stamp + 48'h100_0000_0000, 32767, -32768, 32767, -32768, 32767, -32768);
        push_sample(gen_stamp + 48'h100_0000_0000, 32767, -32768, 32767, -32768, 32767, -32768);
        push_sample(gen_stamp + 48'd5, 0, 0, 0, 0, 0, 0);

        for (int blk = 0; blk < BLOCKS; blk++)
        begin
            wait_drained();
            write_phase_count(block_pc[blk]);
            src_idle_pct  = src_pct[blk / 2];
            snk_stall_pct = snk_pct[blk / 2];
            for (int n = 0; n < BLOCK_ITEMS; n++)
                push_random_sample();
            if (blk == 1)
            begin
                // energy side held off while samples keep coming
                sink_hold = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                sink_hold = 1'b0;
            end
        end
        wait_drained();

        $display("%0d samples integrated over phase counts 0 to 3, dt clamp, timestamp wrap",
                 samples_accepted);
        $display("%0d energy items checked, %0d with the clamp flag, %0d mismatches",
                 results_checked, flagged_results, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule
